@@ rtl/core/brle_pkg.sv @@
// Shared types and constants for the byte RLE run decoder.
// No dependencies; compiled before the interfaces and modules.
package brle_pkg;

  localparam int BYTE_W   = 8;
  localparam int COUNT_W  = 7;
  localparam int LENGTH_W = 16;

  // Header byte fields
  localparam int           RUN_FLAG_BIT = 7;
  localparam logic [7:0]   COUNT_MASK   = 8'h7f;
  localparam logic [7:0]   RUN_FLAG     = 8'h80;

  typedef enum logic [4:0] {
    PH_LEN_LO  = 5'b00001,
    PH_LEN_HI  = 5'b00010,
    PH_HEADER  = 5'b00100,
    PH_RUNVAL  = 5'b01000,
    PH_LITERAL = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t               phase;
    logic [BYTE_W-1:0]    length_low;
    logic [LENGTH_W-1:0]  bytes_left;
    logic [COUNT_W-1:0]   run_left;
  } dec_state_t;

  typedef struct packed {
    logic                 valid;
    logic [BYTE_W-1:0]    value;
    logic [COUNT_W-1:0]   repeat_count;
    logic                 seg_end;
  } dec_result_t;

endpackage

@@ rtl/core/brle_in_if.sv @@
// Input channel of the byte RLE run decoder: one compressed byte per transaction.
// Depends on brle_pkg.
interface brle_in_if;
  import brle_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

@@ rtl/core/brle_out_if.sv @@
// Output channel of the byte RLE run decoder: one (value, repeat, end) result
// per transaction. Depends on brle_pkg.
interface brle_out_if;
  import brle_pkg::*;

  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  out_value;
  logic [COUNT_W-1:0] out_repeat;
  logic               seg_end;

  modport source (output valid, output out_value, output out_repeat, output seg_end,
                  input ready);
  modport sink   (input valid, input out_value, input out_repeat, input seg_end,
                  output ready);
endinterface

@@ rtl/core/brle_step.sv @@
// Next-state and result logic for one compressed byte of the RLE decoder.
// Purely combinational; depends on brle_pkg.
module brle_step (
  input  brle_pkg::dec_state_t        cur,
  input  logic [brle_pkg::BYTE_W-1:0] in_byte,
  output brle_pkg::dec_state_t        nxt,
  output brle_pkg::dec_result_t       res
);
  import brle_pkg::*;

  logic [LENGTH_W-1:0] bytes_dec;
  logic [LENGTH_W-1:0] length_full;
  logic [COUNT_W-1:0]  count;
  logic [COUNT_W-1:0]  run_dec;
  logic                dec_done;

  // Count coded bytes down, holding at zero once the length is met
  assign bytes_dec   = (cur.bytes_left != '0) ? cur.bytes_left - LENGTH_W'(1) : '0;
  assign dec_done    = (bytes_dec == '0);
  assign length_full = {in_byte, cur.length_low};
  assign count       = COUNT_W'(in_byte & COUNT_MASK);
  assign run_dec     = cur.run_left - COUNT_W'(1);

  always_comb begin
    nxt = cur;
    res = '0;
    unique case (cur.phase)
      PH_LEN_HI: begin
        nxt.bytes_left = length_full;
        nxt.phase      = PH_HEADER;
        // Zero length ends the segment at once
        if (length_full == '0) begin
          nxt.phase   = PH_LEN_LO;
          res.valid   = 1'b1;
          res.seg_end = 1'b1;
        end
      end
      PH_HEADER: begin
        nxt.bytes_left = bytes_dec;
        nxt.run_left   = count;
        if ((in_byte & RUN_FLAG) != '0) begin
          nxt.phase = PH_RUNVAL;
        end else if (count != '0) begin
          nxt.phase = PH_LITERAL;
        end else if (dec_done) begin
          // Empty literal header at the length: end-only result
          nxt.phase   = PH_LEN_LO;
          res.valid   = 1'b1;
          res.seg_end = 1'b1;
        end
      end
      PH_RUNVAL: begin
        nxt.bytes_left = bytes_dec;
        nxt.phase      = dec_done ? PH_LEN_LO : PH_HEADER;
        if (cur.run_left != '0) begin
          res.valid        = 1'b1;
          res.value        = in_byte;
          res.repeat_count = cur.run_left;
          res.seg_end      = dec_done;
          nxt.run_left     = '0;
        end else if (dec_done) begin
          res.valid   = 1'b1;
          res.seg_end = 1'b1;
        end
      end
      PH_LITERAL: begin
        nxt.bytes_left   = bytes_dec;
        nxt.run_left     = run_dec;
        res.valid        = 1'b1;
        res.value        = in_byte;
        res.repeat_count = COUNT_W'(1);
        // Last literal of the group: header due, check the length
        if (run_dec == '0) begin
          nxt.phase   = dec_done ? PH_LEN_LO : PH_HEADER;
          res.seg_end = dec_done;
        end
      end
      default: begin
        // Length low byte; unused codes land here too
        nxt.length_low = in_byte;
        nxt.phase      = PH_LEN_HI;
      end
    endcase
  end

endmodule

@@ rtl/core/byte_rle_run_decoder_core.sv @@
// Top level of the byte RLE run decoder: state registers, result register
// and handshakes. Depends on brle_pkg, brle_in_if, brle_out_if, brle_step.
//
// Usage:
//   in_ch carries one compressed byte per transaction: a segment is the
//   16-bit length (low byte first) followed by header and data bytes.
//   out_ch carries (out_value, out_repeat, seg_end) results. A run with a nonzero
//   count yields one result with the full repeat count, each literal byte yields one result
//   with repeat 1, and the segment end is flagged on the last result (or on
//   an end-only result with value and repeat zero).
//   The result of an accepted byte is registered in the result register and
//   shows on out_ch in the next cycle. Throughput: one byte per cycle while
//   out_ch does not stall, set by the single decode step between the state registers and the result register.
//   Stall: the result register holds while out_ch.ready is low; in_ch.ready
//   stays high as long as the result register is empty or being drained,
//   so bytes that give no result keep flowing only when no result waits.
//   Reset (rst, synchronous): the decoder waits for a length low byte and
//   the result register is empty.
module byte_rle_run_decoder_core (
  input  logic       clk,
  input  logic       rst,
  brle_in_if.sink    in_ch,
  brle_out_if.source out_ch
);
  import brle_pkg::*;

  dec_state_t  state;
  dec_state_t  state_next;
  dec_result_t step_res;
  logic        out_valid;
  logic        in_take;

  brle_step u_step (
    .cur     (state),
    .in_byte (in_ch.in_byte),
    .nxt     (state_next),
    .res     (step_res)
  );

  // Accept when the result register is free or drains this cycle
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_take     = in_ch.valid && in_ch.ready;

  // Advance decoder state on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= PH_LEN_LO;
      state.length_low <= '0;
      state.bytes_left <= '0;
      state.run_left   <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Result register valid: load on a result, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= step_res.valid;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_take && step_res.valid) begin
      out_ch.out_value  <= step_res.value;
      out_ch.out_repeat <= step_res.repeat_count;
      out_ch.seg_end    <= step_res.seg_end;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for byte_rle_run_decoder_core: drives compressed segments,
// predicts (value, count, end) pairs and checks every output transaction in order.
// Depends on brle_pkg, brle_in_if, brle_out_if and the decoder RTL.
module testbench;
  import brle_pkg::*;

  localparam int CLK_HALF     = 2;
  localparam int RESET_CYCLES = 9;
  localparam int RAND_ITEMS   = 1600;
  localparam int LIMIT_CYCLES = 600000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              drain_first;
  } coded_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]  value;
    logic [COUNT_W-1:0] count;
    logic               seg_end;
  } pair_t;

  logic clk;
  logic rst;

  brle_in_if  in_ch();
  brle_out_if out_ch();

  byte_rle_run_decoder_core dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  coded_item_t coded_stream[$];
  pair_t       expected_pairs[$];

  // Decoder state as predicted from the accepted bytes
  phase_t              dec_phase;
  logic [BYTE_W-1:0]   dec_len_lo;
  logic [LENGTH_W-1:0] dec_left;
  logic [COUNT_W-1:0]  dec_run;

  int mismatches;
  int bytes_sent;
  int pairs_seen;
  int segments_closed;
  int drain_pauses;
  int send_idle;
  int send_calm;
  int recv_stall;
  int recv_calm;

  // Clock
  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Hard limit on the run
  initial begin
    #(LIMIT_CYCLES * 2 * CLK_HALF);
    $display("timeout: %0d bytes sent, %0d pairs pending", bytes_sent,
             expected_pairs.size());
    $display("== FAIL ==");
    $finish;
  end

  function automatic void expect_pair(logic [BYTE_W-1:0] v, logic [COUNT_W-1:0] n,
                                      logic e);
    pair_t p;
    p.value   = v;
    p.count   = n;
    p.seg_end = e;
    expected_pairs.push_back(p);
  endfunction

  // Advance the predicted decoder by one accepted byte
  function automatic void decode_byte(logic [BYTE_W-1:0] b);
    logic done;
    done = 1'b0;
    case (dec_phase)
      PH_LEN_HI: begin
        dec_left  = {b, dec_len_lo};
        dec_phase = PH_HEADER;
        if (dec_left == '0) begin
          dec_phase = PH_LEN_LO;
          expect_pair('0, '0, 1'b1);
        end
      end
      PH_HEADER: begin
        if (dec_left != '0) dec_left = dec_left - LENGTH_W'(1);
        dec_run = b[COUNT_W-1:0];
        if (b[RUN_FLAG_BIT]) begin
          dec_phase = PH_RUNVAL;
        end else if (dec_run != '0) begin
          dec_phase = PH_LITERAL;
        end else if (dec_left == '0) begin
          dec_phase = PH_LEN_LO;
          expect_pair('0, '0, 1'b1);
        end
      end
      PH_RUNVAL: begin
        if (dec_left != '0) dec_left = dec_left - LENGTH_W'(1);
        dec_phase = PH_HEADER;
        done = (dec_left == '0);
        if (done) dec_phase = PH_LEN_LO;
        if (dec_run != '0) begin
          expect_pair(b, dec_run, done);
          dec_run = '0;
        end else if (done) begin
          expect_pair('0, '0, 1'b1);
        end
      end
      PH_LITERAL: begin
        if (dec_left != '0) dec_left = dec_left - LENGTH_W'(1);
        dec_run = dec_run - COUNT_W'(1);
        if (dec_run == '0) begin
          dec_phase = PH_HEADER;
          if (dec_left == '0) begin
            done      = 1'b1;
            dec_phase = PH_LEN_LO;
          end
        end
        expect_pair(b, 7'd1, done);
      end
      default: begin
        dec_len_lo = b;
        dec_phase  = PH_LEN_HI;
      end
    endcase
  endfunction

  // Idle length: mostly short, a few long, with calm stretches of none
  function automatic int draw_idle(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 120);
      return 0;
    end
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic void queue_byte(logic [BYTE_W-1:0] b, logic drain = 1'b0);
    coded_item_t it;
    it.data        = b;
    it.drain_first = drain;
    coded_stream.push_back(it);
  endfunction

  function automatic logic [BYTE_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hff;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Queue one segment of the given coded length; its last group may run past the length
  function automatic void queue_segment(int len, logic drain);
    int used;
    int cnt;
    int r;
    queue_byte(len[7:0], drain);
    queue_byte(len[15:8]);
    used = 0;
    while (used < len) begin
      if ($urandom_range(0, 1) == 1) begin
        r   = $urandom_range(0, 9);
        cnt = (r == 0) ? 0 : (r == 1) ? 127 : $urandom_range(1, 127);
        queue_byte(RUN_FLAG | cnt[7:0]);
        queue_byte(rand_value());
        used += 2;
      end else begin
        r   = $urandom_range(0, 99);
        cnt = (r < 12) ? 0 : (r < 97) ? $urandom_range(1, 8) : $urandom_range(9, 127);
        queue_byte(cnt[7:0] & COUNT_MASK);
        for (int i = 0; i < cnt; i++) queue_byte(rand_value());
        used += 1 + cnt;
      end
    end
  endfunction

  // Driver: present queued bytes, predict each accepted transaction
  always @(posedge clk) begin : drive_bytes
    logic              nv;
    logic [BYTE_W-1:0] nb;
    nv = in_ch.valid;
    nb = in_ch.in_byte;
    if (rst) begin
      nv        = 1'b0;
      send_idle = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.in_byte);
        bytes_sent++;
        nv        = 1'b0;
        send_idle = draw_idle(send_calm);
      end
      if (!nv) begin
        nb = BYTE_W'($urandom_range(0, 255));
        if (send_idle > 0) begin
          send_idle--;
        end else if (coded_stream.size() > 0) begin
          // Hold a drain-first byte until every pending pair has come out
          if (!coded_stream[0].drain_first || expected_pairs.size() == 0) begin
            if (coded_stream[0].drain_first) drain_pauses++;
            nb = coded_stream[0].data;
            nv = 1'b1;
            coded_stream.pop_front();
          end
        end
      end
    end
    in_ch.valid   <= nv;
    in_ch.in_byte <= nb;
  end

  function automatic void report_mismatch(pair_t want, logic have_want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      if (have_want)
        $display("mismatch: expected value %02h count %0d end %0b, got value %02h count %0d end %0b",
                 want.value, want.count, want.seg_end,
                 out_ch.out_value, out_ch.out_repeat, out_ch.seg_end);
      else
        $display("unexpected pair: value %02h count %0d end %0b",
                 out_ch.out_value, out_ch.out_repeat, out_ch.seg_end);
    end
  endfunction

  // Monitor: check each output transaction, stall ready at random
  always @(posedge clk) begin : check_pairs
    pair_t want;
    logic  nr;
    if (rst) begin
      nr         = 1'b1;
      recv_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        pairs_seen++;
        if (out_ch.seg_end) segments_closed++;
        if (expected_pairs.size() == 0) begin
          want = '0;
          report_mismatch(want, 1'b0);
        end else begin
          want = expected_pairs.pop_front();
          if (out_ch.out_value !== want.value || out_ch.out_repeat !== want.count ||
              out_ch.seg_end !== want.seg_end)
            report_mismatch(want, 1'b1);
        end
      end
      if (recv_stall > 0) begin
        nr = 1'b0;
        recv_stall--;
      end else begin
        nr         = 1'b1;
        recv_stall = draw_idle(recv_calm);
      end
    end
    out_ch.ready <= nr;
  end

  // Stimulus, reset and end of run
  initial begin
    int len;
    int r;
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.in_byte   = '0;
    out_ch.ready    = 1'b0;
    dec_phase       = PH_LEN_LO;
    dec_len_lo      = '0;
    dec_left        = '0;
    dec_run         = '0;
    mismatches      = 0;
    bytes_sent      = 0;
    pairs_seen      = 0;
    segments_closed = 0;
    drain_pauses    = 0;
    send_idle       = 0;
    send_calm       = 0;
    recv_stall      = 0;
    recv_calm       = 0;

    // Zero-length segment: end-only pair on the length high byte
    queue_byte(8'h00); queue_byte(8'h00);
    // Longest run of the top value, segment ends on the value byte
    queue_byte(8'h02); queue_byte(8'h00); queue_byte(8'hff); queue_byte(8'hff);
    // Run of zero copies, then a literal header of zero count closing the segment
    queue_byte(8'h03); queue_byte(8'h00);
    queue_byte(RUN_FLAG); queue_byte(8'h55); queue_byte(8'h00);
    // Run of zero copies closing the segment
    queue_byte(8'h02); queue_byte(8'h00, 1'b1); queue_byte(RUN_FLAG); queue_byte(8'haa);
    // Literals straddling the length, end flagged on the last literal
    queue_byte(8'h02); queue_byte(8'h00); queue_byte(8'h03);
    queue_byte(8'h11); queue_byte(8'h22); queue_byte(8'h00);

    // Random part: mostly generated segments, some noise bytes
    while (coded_stream.size() < RAND_ITEMS + 21) begin
      r = $urandom_range(0, 99);
      if (r < 85) begin
        r = $urandom_range(0, 99);
        if (r < 8) len = 0;
        else if (r < 95) len = $urandom_range(1, 24);
        else len = $urandom_range(100, 300);
        queue_segment(len, (coded_stream.size() == 21) || ($urandom_range(0, 29) == 0));
      end else begin
        r = $urandom_range(1, 8);
        for (int i = 0; i < r; i++) queue_byte(BYTE_W'($urandom_range(0, 255)));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Wait until every byte is accepted and every pair has come out
    while (coded_stream.size() > 0 || in_ch.valid) @(negedge clk);
    while (expected_pairs.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("sent %0d coded bytes, checked %0d pairs, %0d segment ends, %0d drain pauses",
             bytes_sent, pairs_seen, segments_closed, drain_pauses);
    $display("mismatches %0d, pairs left over %0d", mismatches, expected_pairs.size());
    if (mismatches == 0 && expected_pairs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/brle_pkg.sv
rtl/core/brle_in_if.sv
rtl/core/brle_out_if.sv
rtl/core/brle_step.sv
rtl/core/byte_rle_run_decoder_core.sv
tb/testbench.sv
